// ===== rtl/wsd_pkg.sv =====
// Package for the whitespace steganography decoder.
// It holds the character codes, counter limits, tag lengths, item types and tag lookup functions.
// No dependencies.
package wsd_pkg;

   // Character codes of the carrier text.
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LT      = 8'h3C;

   // Bit counter limits.
   localparam logic [3:0] BYTE_BITS = 4'd8;
   localparam logic [3:0] COUNT_MAX = 4'd9;

   // Tag lengths.
   localparam logic [2:0] OPEN_LEN  = 3'd5;
   localparam logic [2:0] CLOSE_LEN = 3'd6;

   // What one character means to the bit accumulator.
   typedef enum logic [1:0] {
      KIND_OTHER   = 2'd0,
      KIND_ZERO    = 2'd1,
      KIND_ONE     = 2'd2,
      KIND_NEWLINE = 2'd3
   } char_kind_type;

   // A classified character, passed from the front to the back.
   typedef struct packed {
      char_kind_type kind;
      logic          open_done;
      logic          close_done;
   } class_item_type;

   // Characters of "<pre>" by position.
   function automatic logic [7:0] open_tag_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h3C;
         3'd1:    ch = 8'h70;
         3'd2:    ch = 8'h72;
         3'd3:    ch = 8'h65;
         3'd4:    ch = 8'h3E;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Characters of "</pre>" by position.
   function automatic logic [7:0] close_tag_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h3C;
         3'd1:    ch = 8'h2F;
         3'd2:    ch = 8'h70;
         3'd3:    ch = 8'h72;
         3'd4:    ch = 8'h65;
         3'd5:    ch = 8'h3E;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/whitespace_stego_decoder_top.sv =====
// Top level of the whitespace steganography decoder.
// Depends on wsd_pkg, wsd_fifo, wsd_front and wsd_back.
//
// Usage:
//   Input channel: present one carrier text character on req_text_char with
//   req_push high; the beat is taken at a rising edge where req_full is low.
//   Tabs give 1 bits, spaces 0 bits, least significant first; a newline
//   clears the partial byte; "<pre>" and "</pre>" switch suppression.
//   Result channel: while rsp_empty is low the oldest recovered byte is on
//   rsp_hidden_byte; it is taken at a rising edge where rsp_pop is high.
// Path: an accepted character is written into the middle queue; the back stage
//   carries it out once the output queue has room, writes its byte into the
//   output queue, and the byte then shows on the result ports.
// Throughput: one character per cycle while the output queue has room, set by
//   the back stage update; the tag matchers advance on each accepted beat.
// Reset: synchronous and active high; it empties both queues and clears the
//   bit count, accumulator, suppression and tag progress. No clearing pass.
// Stalls: when rsp_pop stays low the output queue fills, the back stage holds,
//   the middle queue fills and req_full rises; nothing is lost or repeated.
module whitespace_stego_decoder_top
   import wsd_pkg::*;
#(
   parameter int MID_DEPTH = 2,
   parameter int OUT_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_text_char,
   output logic       req_full,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_hidden_byte
);

   localparam int ITEM_W = $bits(class_item_type);

   class_item_type front_item, back_item;
   logic [ITEM_W-1:0] back_item_bits;
   logic mid_full, mid_empty, mid_pop;
   logic accept;
   logic out_full, out_push;
   logic [7:0] out_byte;

   // Input beats are taken while the middle queue has room.
   assign req_full = mid_full;
   assign accept   = req_push && !mid_full;

   wsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_char (req_text_char),
      .item      (front_item)
   );

   wsd_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .wr_data (front_item),
      .full    (mid_full),
      .pop     (mid_pop),
      .empty   (mid_empty),
      .rd_data (back_item_bits)
   );

   assign back_item = class_item_type'(back_item_bits);

   wsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!mid_empty),
      .item       (back_item),
      .item_pop   (mid_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_byte   (out_byte)
   );

   wsd_fifo #(
      .WIDTH (8),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_byte),
      .full    (out_full),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_hidden_byte)
   );

endmodule

// ===== rtl/wsd_fifo.sv =====
// Small register-based queue used between the decoder stages and at the output.
// Depends on nothing but its parameters.
module wsd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // Status flags and beat handshakes.
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/wsd_front.sv =====
// Front stage of the decoder: classifies each character and tracks the two tag matchers.
// Depends on wsd_pkg.
module wsd_front
   import wsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     text_char,
   output class_item_type item
);

   logic [2:0] open_prog_ff, open_prog_in;
   logic [2:0] close_prog_ff, close_prog_in;
   logic       open_done, close_done;
   logic       is_lt;

   assign is_lt = (text_char == CH_LT);

   // Character class for the bit accumulator.
   always_comb begin
      unique case (text_char)
         CH_TAB:     item.kind = KIND_ONE;
         CH_SPACE:   item.kind = KIND_ZERO;
         CH_NEWLINE: item.kind = KIND_NEWLINE;
         default:    item.kind = KIND_OTHER;
      endcase
      item.open_done  = open_done;
      item.close_done = close_done;
   end

   // Open tag matcher; a mismatch falls back to one if the character starts a tag.
   always_comb begin
      open_done = 1'b0;
      if (text_char == open_tag_char(open_prog_ff)) begin
         if (open_prog_ff + 3'd1 == OPEN_LEN) begin
            open_done    = 1'b1;
            open_prog_in = '0;
         end else begin
            open_prog_in = open_prog_ff + 3'd1;
         end
      end else begin
         open_prog_in = is_lt ? 3'd1 : 3'd0;
      end
   end

   // Close tag matcher, same rules.
   always_comb begin
      close_done = 1'b0;
      if (text_char == close_tag_char(close_prog_ff)) begin
         if (close_prog_ff + 3'd1 == CLOSE_LEN) begin
            close_done    = 1'b1;
            close_prog_in = '0;
         end else begin
            close_prog_in = close_prog_ff + 3'd1;
         end
      end else begin
         close_prog_in = is_lt ? 3'd1 : 3'd0;
      end
   end

   // Progress advances only on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_prog_ff  <= '0;
         close_prog_ff <= '0;
      end else if (accept) begin
         open_prog_ff  <= open_prog_in;
         close_prog_ff <= close_prog_in;
      end
   end

endmodule

// ===== rtl/wsd_back.sv =====
// Back stage of the decoder: gathers bits, tracks suppression and emits finished bytes.
// Depends on wsd_pkg.
module wsd_back
   import wsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   input  class_item_type item,
   output logic           item_pop,
   input  logic           out_full,
   output logic           out_push,
   output logic [7:0]     out_byte
);

   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] acc_ff, acc_in;
   logic       suppress_ff, suppress_in;
   logic [3:0] count_bits;
   logic [7:0] acc_bits;
   logic       process, emit;

   // An item is carried out whenever one waits and the output queue has room.
   assign process  = item_valid && !out_full;
   assign item_pop = process;

   // Bit gathering, then suppression, then the emit check.
   always_comb begin
      count_bits = bit_count_ff;
      acc_bits   = acc_ff;
      unique case (item.kind)
         KIND_ZERO, KIND_ONE: begin
            if (item.kind == KIND_ONE && bit_count_ff < BYTE_BITS) begin
               acc_bits = acc_ff | (8'd1 << bit_count_ff[2:0]);
            end
            if (bit_count_ff < COUNT_MAX) begin
               count_bits = bit_count_ff + 4'd1;
            end
         end
         KIND_NEWLINE: begin
            count_bits = '0;
            acc_bits   = '0;
         end
         default: begin
            count_bits = bit_count_ff;
            acc_bits   = acc_ff;
         end
      endcase

      priority if (item.open_done) begin
         suppress_in = 1'b1;
      end else if (item.close_done) begin
         suppress_in = 1'b0;
      end else begin
         suppress_in = suppress_ff;
      end

      emit = (count_bits == BYTE_BITS) && !suppress_in;
      if (emit) begin
         bit_count_in = '0;
         acc_in       = '0;
      end else begin
         bit_count_in = count_bits;
         acc_in       = acc_bits;
      end
   end

   assign out_push = process && emit;
   assign out_byte = acc_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= '0;
         acc_ff       <= '0;
         suppress_ff  <= 1'b0;
      end else if (process) begin
         bit_count_ff <= bit_count_in;
         acc_ff       <= acc_in;
         suppress_ff  <= suppress_in;
      end
   end

   // The count never passes its saturation point.
   assert property (@(posedge clock) disable iff (reset) bit_count_ff <= COUNT_MAX)
      else $error("bit count above saturation");

   // A full byte outside suppression is always emitted at once.
   assert property (@(posedge clock) disable iff (reset)
      !suppress_ff |-> bit_count_ff != BYTE_BITS)
      else $error("full byte left pending while not suppressed");

   // A newline always leaves an empty count.
   assert property (@(posedge clock) disable iff (reset)
      process && item.kind == KIND_NEWLINE |=> bit_count_ff == '0 && acc_ff == '0)
      else $error("newline did not clear the accumulator");

   // A result is only pushed when the output queue can take it.
   assert property (@(posedge clock) disable iff (reset) out_push |-> !out_full && item_valid)
      else $error("result pushed without room or item");

endmodule

// ===== bench/whitespace_stego_decoder_top_test.sv =====
// Testbench for whitespace_stego_decoder_top: streams carrier text and checks recovered bytes.
// Holds its own byte tracker and a queue of due bytes. Random idling is drawn on both sides.
// Depends on wsd_pkg and the RTL of the decoder.
`timescale 1ns / 1ps

module whitespace_stego_decoder_top_test;
   import wsd_pkg::*;

   localparam int ITEM_TARGET   = 1550;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 400000;

   // Tracks the decoder state for every accepted character and keeps the bytes it owes.
   class hidden_byte_tracker;
      logic [3:0] bit_count;
      logic [7:0] partial_byte;
      logic       suppressed;
      logic [2:0] open_seen;
      logic [2:0] close_seen;
      logic [7:0] bytes_due[$];
      string      open_tag = "<pre>";
      string      close_tag = "</pre>";
      int         errors;
      int         chars_seen;
      int         bytes_checked;

      function new();
         bit_count = '0;
         partial_byte = '0;
         suppressed = 1'b0;
         open_seen = '0;
         close_seen = '0;
         errors = 0;
         chars_seen = 0;
         bytes_checked = 0;
      endfunction

      // Advances one tag matcher; a miss restarts at one if the character opens a tag.
      function bit tag_step(inout logic [2:0] seen, input string tag, input logic [7:0] c);
         logic [2:0] p;
         p = seen;
         if (p >= tag.len())
            p = '0;
         if (c == tag[p]) begin
            p++;
            if (p == tag.len()) begin
               seen = '0;
               return 1'b1;
            end
            seen = p;
            return 1'b0;
         end
         seen = (c == tag[0]) ? 3'd1 : 3'd0;
         return 1'b0;
      endfunction

      // Notes one accepted character and queues the byte it completes, if any.
      function void take_char(input logic [7:0] c);
         bit open_done;
         bit close_done;
         chars_seen++;
         if (c == CH_TAB || c == CH_SPACE) begin
            if (bit_count < BYTE_BITS && c == CH_TAB)
               partial_byte[bit_count[2:0]] = 1'b1;
            if (bit_count < COUNT_MAX)
               bit_count++;
         end else if (c == CH_NEWLINE) begin
            bit_count = '0;
            partial_byte = '0;
         end
         open_done = tag_step(open_seen, open_tag, c);
         close_done = tag_step(close_seen, close_tag, c);
         if (open_done)
            suppressed = 1'b1;
         else if (close_done)
            suppressed = 1'b0;
         if (bit_count == BYTE_BITS && !suppressed) begin
            bytes_due.push_back(partial_byte);
            bit_count = '0;
            partial_byte = '0;
         end
      endfunction

      // Compares one delivered byte with the oldest one owed.
      function void match_byte(input logic [7:0] got);
         logic [7:0] want;
         if (bytes_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected hidden_byte, expected none, got %02h", $time, got);
            return;
         end
         want = bytes_due.pop_front();
         bytes_checked++;
         if (got !== want) begin
            errors++;
            $display("%0t: hidden_byte mismatch, expected %02h, got %02h", $time, want, got);
         end
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic [7:0] req_text_char = 8'h00;
   logic       req_full;
   logic       rsp_pop = 1'b0;
   logic       rsp_empty;
   logic [7:0] rsp_hidden_byte;

   hidden_byte_tracker tracker = new();
   int unsigned cycle_count = 0;
   int          tx_calm = 0;
   int          rx_calm = 0;
   bit          sender_fast = 1'b0;
   bit          hold_results = 1'b0;

   whitespace_stego_decoder_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_text_char  (req_text_char),
      .req_full       (req_full),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_hidden_byte(rsp_hidden_byte)
   );

   // Free-running clock and an initial reset pulse.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Run guard: ends a hung simulation.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Draws the idle cycles before one beat; now and then a calm stretch with no idling.
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   // Offers one character and waits until the decoder takes it.
   task automatic push_char(input logic [7:0] c);
      int gap;
      gap = sender_fast ? 0 : draw_gap(tx_calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_text_char <= c;
      do @(posedge clock); while (req_full);
      tracker.take_char(c);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i]);
   endtask

   // Sends a byte as tabs and spaces, low bit first, optionally with stray text between bits.
   task automatic push_byte(input logic [7:0] value, input bit noisy);
      logic [7:0] c;
      for (int i = 0; i < 8; i++) begin
         if (noisy && $urandom_range(0, 5) == 0) begin
            do c = 8'($urandom_range(0, 255));
            while (c == CH_TAB || c == CH_SPACE || c == CH_NEWLINE);
            push_char(c);
         end
         push_char(value[i] ? CH_TAB : CH_SPACE);
      end
   endtask

   task automatic push_bits(input int n);
      repeat (n) push_char($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
   endtask

   // One random stretch of carrier text; mostly well-formed bytes and sections.
   task automatic push_segment();
      logic [7:0] value;
      string      tag;
      int         cut;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            value = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
               value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            push_byte(value, $urandom_range(0, 3) == 0);
         end
         4: begin
            push_bits($urandom_range(1, 7));
            push_char(CH_NEWLINE);
         end
         5, 6: begin
            // A suppressed section, often with exactly one byte's worth of bits inside.
            push_text("<pre>");
            push_bits($urandom_range(0, 1) ? 8 : $urandom_range(0, 12));
            if ($urandom_range(0, 4) == 0)
               push_char(CH_NEWLINE);
            push_text("</pre>");
         end
         7: begin
            if ($urandom_range(0, 1) == 1)
               tag = "<pre>";
            else
               tag = "</pre>";
            cut = $urandom_range(1, tag.len() - 1);
            push_text(tag.substr(0, cut - 1));
            push_char(8'($urandom_range(0, 255)));
         end
         8: begin
            if ($urandom_range(0, 1) == 1)
               push_text("</pre>");
            else
               push_text("<pre><pre>");
         end
         default: repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)));
      endcase
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_results) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end else begin
            gap = draw_gap(rx_calm);
            if (gap > 0) begin
               rsp_pop <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         tracker.match_byte(rsp_hidden_byte);
      end
   end

   // Text side: directed cases, a stall of the result side, then random text.
   initial begin
      bit drained_mid;
      drained_mid = 1'b0;
      while (reset) @(posedge clock);

      // Zero byte and all-ones byte carry no bits.
      push_char(8'h00);
      push_char(8'hFF);
      // A doubled '<' must still let the open tag match; then a full byte of bits inside
      // the section is held, and the close tag releases it on its last character.
      push_text("<<pre>");
      push_byte(8'h55, 1'b0);
      push_text("</pre>");
      // A partial byte is thrown away by a newline.
      push_char(CH_TAB);
      push_char(CH_TAB);
      push_char(CH_NEWLINE);

      // Hold the result side while bytes pour in, so that the input stalls.
      sender_fast = 1'b1;
      hold_results = 1'b1;
      repeat (6) push_byte(8'($urandom_range(0, 255)), 1'b0);
      sender_fast = 1'b0;

      while (tracker.chars_seen < ITEM_TARGET) begin
         if (!drained_mid && tracker.chars_seen >= ITEM_TARGET / 2) begin
            drained_mid = 1'b1;
            req_push <= 1'b0;
            do @(posedge clock); while (tracker.bytes_due.size() != 0);
         end
         push_segment();
      end
      req_push <= 1'b0;

      while (tracker.bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Streamed %0d carrier characters and checked %0d recovered bytes,",
               tracker.chars_seen, tracker.bytes_checked);
      $display("including suppressed sections, broken tags and a long stall of the results.");
      if (tracker.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
